### design/cchs_pkg.sv
// Shared types, constants and the CRC32C step function for the chained hash set.
package cchs_pkg;

   localparam int MAX_BUCKETS_DEF = 1024;
   localparam int POOL_NODES_DEF  = 1024;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
   localparam logic [10:0] BUCKET_COUNT_RESET = 11'd1024;
   localparam int CFG_BUCKET_COUNT = 0;
   localparam int CRC_BITS_PER_STEP = 8;
   localparam int COUNT_W = 11;
   localparam int BIDX_W = 10;

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CRC,
      ST_MOD,
      ST_HEAD_RD,
      ST_HEAD_WAIT,
      ST_DECIDE,
      ST_NODE_RD,
      ST_NODE_WAIT,
      ST_NODE_CMP,
      ST_INS_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic crc_step;
      logic mod_start;
      logic head_rd;
      logic node_rd;
      logic follow;
      logic ins_wr;
      logic set_ok;
      logic clr_ok;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic crc_last;
      logic mod_done;
      logic op_query;
      logic cur_null;
      logic key_match;
      logic walk_limit;
      logic pool_full;
   } sts_type;

   // Eight reflected CRC32C bit steps on the low byte of the running value.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] v;
      v = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         v = (v >> 1) ^ (v[0] ? CRC_POLY : 32'd0);
      end
      return v;
   endfunction

endpackage

### design/crc32c_chained_hash_set.sv
// Top level of the CRC32C chained hash set: CSR port, sequencer and datapath.
// A set of 32-byte keys in chained buckets. Each request beat inserts or looks up one
// key and yields exactly one response beat. An item is hashed and reduced (one CRC
// byte a cycle over 32 bytes, then a bit-serial remainder against the effective
// bucket count), then the bucket head is read, and a query then walks the chain node
// by node; the single-port node memories set the walk cost. After reset a clearing
// pass nulls the bucket heads, during which no request is accepted; CSR writes are
// taken as usual.
module crc32c_chained_hash_set #(
   parameter int MAX_BUCKETS = cchs_pkg::MAX_BUCKETS_DEF,
   parameter int POOL_NODES  = cchs_pkg::POOL_NODES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [63:0] req_key_word_0,
   input  logic [63:0] req_key_word_1,
   input  logic [63:0] req_key_word_2,
   input  logic [63:0] req_key_word_3,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_success,
   output logic [9:0]  rsp_bucket_index,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cchs_pkg::cmd_type cmd;
   cchs_pkg::sts_type sts;
   logic clearing;
   logic ctrl_stall;
   logic [cchs_pkg::COUNT_W-1:0] bucket_count_ff;

   // CSR: single register at address 0, always ready
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= cchs_pkg::BUCKET_COUNT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr == 2'(cchs_pkg::CFG_BUCKET_COUNT * 4)) begin
         bucket_count_ff <= csr_pwdata[cchs_pkg::COUNT_W-1:0];
      end
   end
   assign csr_prdata = (csr_paddr == 2'(cchs_pkg::CFG_BUCKET_COUNT * 4)) ?
                       {21'd0, bucket_count_ff} : 32'd0;

   // hold requests off while heads are being cleared
   assign req_stall = ctrl_stall || clearing;

   cchs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid && !clearing),
      .req_stall (ctrl_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cchs_datapath #(
      .MAX_BUCKETS (MAX_BUCKETS),
      .POOL_NODES  (POOL_NODES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_operation    (req_operation),
      .req_key_word_0   (req_key_word_0),
      .req_key_word_1   (req_key_word_1),
      .req_key_word_2   (req_key_word_2),
      .req_key_word_3   (req_key_word_3),
      .bucket_count     (bucket_count_ff),
      .rsp_success      (rsp_success),
      .rsp_bucket_index (rsp_bucket_index),
      .clearing         (clearing)
   );

   // an accepted request beat launches the hash
   a_load: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> cmd.load)
      else $error("accepted beat did not load the key");

   // no insert write while the pool is full
   a_full: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_wr |-> !sts.pool_full)
      else $error("insert into a full pool");

   // a pending response is held when stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_success) &&
                                   $stable(rsp_bucket_index)))
      else $error("stalled response changed");

endmodule

### design/cchs_ctrl.sv
// Sequencer for the chained hash set: hash, reduce, head lookup, walk or insert.
module cchs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  cchs_pkg::sts_type   sts,
   output cchs_pkg::cmd_type   cmd
);

   cchs_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cchs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign req_stall = (state_ff != cchs_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         cchs_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = cchs_pkg::ST_CRC;
            end
         end
         cchs_pkg::ST_CRC: begin
            cmd.crc_step = 1'b1;
            if (sts.crc_last) begin
               cmd.mod_start = 1'b1;
               state_in = cchs_pkg::ST_MOD;
            end
         end
         cchs_pkg::ST_MOD: begin
            if (sts.mod_done) state_in = cchs_pkg::ST_HEAD_RD;
         end
         cchs_pkg::ST_HEAD_RD: begin
            cmd.head_rd = 1'b1;
            state_in = cchs_pkg::ST_HEAD_WAIT;
         end
         cchs_pkg::ST_HEAD_WAIT: begin
            cmd.clr_ok = 1'b1;
            state_in = cchs_pkg::ST_DECIDE;
         end
         cchs_pkg::ST_DECIDE: begin
            if (!sts.op_query) begin
               if (sts.pool_full) state_in = cchs_pkg::ST_DONE;
               else state_in = cchs_pkg::ST_INS_WR;
            end else if (sts.cur_null || sts.walk_limit) begin
               state_in = cchs_pkg::ST_DONE;
            end else begin
               state_in = cchs_pkg::ST_NODE_RD;
            end
         end
         cchs_pkg::ST_NODE_RD: begin
            cmd.node_rd = 1'b1;
            state_in = cchs_pkg::ST_NODE_WAIT;
         end
         cchs_pkg::ST_NODE_WAIT: begin
            state_in = cchs_pkg::ST_NODE_CMP;
         end
         cchs_pkg::ST_NODE_CMP: begin
            if (sts.key_match) begin
               cmd.set_ok = 1'b1;
               state_in = cchs_pkg::ST_DONE;
            end else begin
               cmd.follow = 1'b1;
               state_in = cchs_pkg::ST_DECIDE;
            end
         end
         cchs_pkg::ST_INS_WR: begin
            cmd.ins_wr = 1'b1;
            cmd.set_ok = 1'b1;
            state_in = cchs_pkg::ST_DONE;
         end
         cchs_pkg::ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = cchs_pkg::ST_IDLE;
            end
         end
         default: state_in = cchs_pkg::ST_IDLE;
      endcase
   end

endmodule

### design/cchs_datapath.sv
// Datapath of the chained hash set: CRC, modulo unit, bucket head and node memories.
module cchs_datapath #(
   parameter int MAX_BUCKETS = cchs_pkg::MAX_BUCKETS_DEF,
   parameter int POOL_NODES  = cchs_pkg::POOL_NODES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cchs_pkg::cmd_type            cmd,
   output cchs_pkg::sts_type            sts,
   input  logic                         req_operation,
   input  logic [63:0]                  req_key_word_0,
   input  logic [63:0]                  req_key_word_1,
   input  logic [63:0]                  req_key_word_2,
   input  logic [63:0]                  req_key_word_3,
   input  logic [cchs_pkg::COUNT_W-1:0] bucket_count,
   output logic                         rsp_success,
   output logic [cchs_pkg::BIDX_W-1:0]  rsp_bucket_index,
   output logic                         clearing
);

   localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int NW = $clog2(POOL_NODES);
   localparam int PW = $clog2(POOL_NODES + 1);
   localparam int CW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS + 1) : 1;
   localparam int DW = (CW > cchs_pkg::COUNT_W) ? CW : cchs_pkg::COUNT_W;

   // key and op latch
   logic [255:0] key_ff;
   logic         op_ff;
   logic [31:0]  crc_ff;
   logic [4:0]   byte_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= {req_key_word_3, req_key_word_2, req_key_word_1, req_key_word_0};
         op_ff  <= req_operation;
         crc_ff <= cchs_pkg::CRC_INIT;
      end else if (cmd.crc_step) begin
         crc_ff <= cchs_pkg::crc_byte(crc_ff, key_ff[{byte_ff, 3'b000} +: 8]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load) byte_ff <= '0;
      else if (cmd.crc_step) byte_ff <= byte_ff + 5'd1;
   end
   assign sts.crc_last = (byte_ff == 5'd31);
   assign sts.op_query = op_ff;

   // effective divisor: zero acts as one, saturate at the bucket count limit
   logic [DW-1:0] div_ext;
   logic [CW-1:0] divisor;
   always_comb begin
      div_ext = DW'(bucket_count);
      if (bucket_count == '0) divisor = CW'(1);
      else if (div_ext > DW'(MAX_BUCKETS)) divisor = CW'(MAX_BUCKETS);
      else divisor = CW'(bucket_count);
   end

   // restoring remainder, one dividend bit a cycle
   logic [CW:0]   rem_ff;
   logic [31:0]   dvd_ff;
   logic [5:0]    mcnt_ff;
   logic          mbusy_ff;
   logic [CW-1:0] div_ff;
   logic [CW:0]   rem_sh;
   always_comb rem_sh = {rem_ff[CW-1:0], dvd_ff[31]};

   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
      end else if (cmd.mod_start) begin
         mbusy_ff <= 1'b1;
      end else if (mbusy_ff && mcnt_ff == 6'd31) begin
         mbusy_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.mod_start) begin
         rem_ff  <= '0;
         dvd_ff  <= cchs_pkg::crc_byte(crc_ff, key_ff[255:248]);
         mcnt_ff <= '0;
         div_ff  <= divisor;
      end else if (mbusy_ff) begin
         dvd_ff  <= {dvd_ff[30:0], 1'b0};
         mcnt_ff <= mcnt_ff + 6'd1;
         if (rem_sh >= {1'b0, div_ff}) rem_ff <= rem_sh - {1'b0, div_ff};
         else rem_ff <= rem_sh;
      end
   end
   assign sts.mod_done = !mbusy_ff && !cmd.mod_start;
   logic [BW-1:0] bucket;
   assign bucket = BW'(rem_ff);

   // bucket head memory with clearing pass after reset
   logic [PW-1:0] heads [MAX_BUCKETS];
   logic [PW-1:0] head_rd_ff;
   logic          clr_ff;
   logic [BW-1:0] clr_idx_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= 1'b1;
         clr_idx_ff <= '0;
      end else if (clr_ff) begin
         clr_idx_ff <= clr_idx_ff + BW'(1);
         if (clr_idx_ff == BW'(MAX_BUCKETS - 1)) clr_ff <= 1'b0;
      end
   end
   assign clearing = clr_ff;

   logic [PW-1:0] used_ff;
   always_ff @(posedge clock) begin
      if (clr_ff) heads[clr_idx_ff] <= '0;
      else if (cmd.ins_wr) heads[bucket] <= used_ff + PW'(1);
      if (cmd.head_rd) head_rd_ff <= heads[bucket];
   end

   always_ff @(posedge clock) begin
      if (reset) used_ff <= '0;
      else if (cmd.ins_wr) used_ff <= used_ff + PW'(1);
   end
   assign sts.pool_full = (used_ff == PW'(POOL_NODES));

   // node memories
   logic [255:0]  node_key  [POOL_NODES];
   logic [PW-1:0] node_next [POOL_NODES];
   logic [255:0]  nkey_ff;
   logic [PW-1:0] nnext_ff;
   logic [PW-1:0] cur_ff;
   logic [PW-1:0] guard_ff;

   always_ff @(posedge clock) begin
      if (cmd.ins_wr) begin
         node_key[NW'(used_ff)]  <= key_ff;
         node_next[NW'(used_ff)] <= head_rd_ff;
      end
      if (cmd.node_rd) begin
         nkey_ff  <= node_key[NW'(cur_ff - PW'(1))];
         nnext_ff <= node_next[NW'(cur_ff - PW'(1))];
      end
   end

   // chain cursor: load from head, advance on a miss
   always_ff @(posedge clock) begin
      if (cmd.clr_ok) begin
         cur_ff <= head_rd_ff;
         guard_ff <= '0;
      end else if (cmd.follow) begin
         cur_ff <= nnext_ff;
         guard_ff <= guard_ff + PW'(1);
      end
   end
   assign sts.cur_null   = (cur_ff == '0) || (cur_ff > PW'(POOL_NODES));
   assign sts.walk_limit = (guard_ff == PW'(POOL_NODES));
   assign sts.key_match  = (nkey_ff == key_ff);

   logic ok_ff;
   always_ff @(posedge clock) begin
      if (cmd.clr_ok) ok_ff <= 1'b0;
      else if (cmd.set_ok) ok_ff <= 1'b1;
   end

   logic                        succ_ff;
   logic [cchs_pkg::BIDX_W-1:0] bidx_ff;
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         succ_ff <= ok_ff;
         bidx_ff <= cchs_pkg::BIDX_W'({{cchs_pkg::BIDX_W{1'b0}}, bucket});
      end
   end
   assign rsp_success = succ_ff;
   assign rsp_bucket_index = bidx_ff;

endmodule
